FILE: design/text_console_cursor_engine_macros.svh
// Assertion macros shared by the console cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge once reset has been released.
`define TCCE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TCCE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define TCCE_ASSERT(name, prop, msg)
`define TCCE_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

FILE: design/tcce_pkg.sv
package tcce_pkg;

  localparam int COL_W  = 9;
  localparam int ROW_W  = 8;
  localparam int COLS_W = 10;
  localparam int ROWS_W = 9;
  localparam int CHAR_W = 8;
  localparam int COLOR_W = 32;

  localparam int TAB_STOP  = 8;
  localparam int MAX_DRAWS = 8;
  localparam int CNT_W     = $clog2(MAX_DRAWS + 1);
  localparam int TAB_W     = $clog2(TAB_STOP + MAX_DRAWS + 1);

  localparam logic [COLS_W-1:0] MAX_COLS   = COLS_W'(512);
  localparam logic [ROWS_W-1:0] MAX_ROWS   = ROWS_W'(256);
  localparam logic [COLS_W-1:0] RESET_COLS = COLS_W'(80);
  localparam logic [ROWS_W-1:0] RESET_ROWS = ROWS_W'(25);

  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

  // Effective grid size, already clamped to its legal range.
  typedef struct packed {
    logic [COLS_W-1:0] cols;
    logic [ROWS_W-1:0] rows;
  } grid_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cursor_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic no_draw;
    logic last;
  } dp_status_t;

  // Column overflow moves to the next row; row overflow returns to the top.
  function automatic cursor_t wrap_cursor(logic [COLS_W-1:0] col,
                                          logic [ROWS_W-1:0] row,
                                          grid_t grid);
    cursor_t res;
    logic [ROWS_W-1:0] r;
    logic [COLS_W-1:0] c;
    r = row;
    c = col;
    if (col >= grid.cols) begin
      r = row + ROWS_W'(1);
      c = '0;
    end
    if (r >= grid.rows) begin
      r = '0;
    end
    res.col = c[COL_W-1:0];
    res.row = r[ROW_W-1:0];
    return res;
  endfunction

endpackage

FILE: design/tcce_cfg.sv
module tcce_cfg
  import tcce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output grid_t       grid_o
);

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  logic [COLS_W-1:0] cols_q, cols_d;
  logic [ROWS_W-1:0] rows_q, rows_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_COLS: cols_d = pwdata[COLS_W-1:0];
        REG_ROWS: rows_d = pwdata[ROWS_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= RESET_COLS;
      rows_q <= RESET_ROWS;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLS: prdata = {{(32 - COLS_W){1'b0}}, cols_q};
      REG_ROWS: prdata = {{(32 - ROWS_W){1'b0}}, rows_q};
      default:  prdata = '0;
    endcase
  end

  // A zero size counts as one cell; oversized values clamp to the maximum.
  always_comb begin
    grid_o.cols = cols_q;
    if (cols_q == '0) begin
      grid_o.cols = COLS_W'(1);
    end else if (cols_q > MAX_COLS) begin
      grid_o.cols = MAX_COLS;
    end
    grid_o.rows = rows_q;
    if (rows_q == '0) begin
      grid_o.rows = ROWS_W'(1);
    end else if (rows_q > MAX_ROWS) begin
      grid_o.rows = MAX_ROWS;
    end
  end

endmodule

FILE: design/tcce_ctrl.sv
module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state_q, state_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!status_i.no_draw) begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!out_stall_i) begin
          cmd_o.step = 1'b1;
          if (status_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/tcce_dpath.sv
module tcce_dpath
  import tcce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grid_t              grid_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [COLOR_W-1:0] fg_color_i,
  input  logic [COLOR_W-1:0] bg_color_i,
  output logic [COL_W-1:0]   cell_col_o,
  output logic [ROW_W-1:0]   cell_row_o,
  output logic [CHAR_W-1:0]  glyph_o,
  output logic [COLOR_W-1:0] draw_fg_o,
  output logic [COLOR_W-1:0] draw_bg_o,
  output logic               last_o
);

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               adv_q, adv_d;
  logic [CHAR_W-1:0]  glyph_q, glyph_d;
  logic [COLOR_W-1:0] fg_q, fg_d;
  logic [COLOR_W-1:0] bg_q, bg_d;

  logic [TAB_W-1:0]   tab_rem;
  logic [TAB_W-1:0]   tab_num;
  logic [CNT_W-1:0]   tab_cnt;
  cursor_t            stepped;
  cursor_t            newline;

  assign status_o.no_draw = (char_code_i == CHAR_NEWLINE);
  assign status_o.last    = (cnt_q == CNT_W'(1));

  // Spaces up to the next tab stop, limited to the longest burst of draws.
  always_comb begin
    tab_rem = TAB_W'(col_q % COL_W'(TAB_STOP));
    tab_num = TAB_W'(TAB_STOP) - tab_rem;
    if (tab_num > TAB_W'(MAX_DRAWS)) begin
      tab_cnt = CNT_W'(MAX_DRAWS);
    end else begin
      tab_cnt = tab_num[CNT_W-1:0];
    end
  end

  // Backspace has already moved the cursor, so its draw is only followed by a wrap.
  assign stepped = wrap_cursor({1'b0, col_q} + COLS_W'(adv_q), {1'b0, row_q}, grid_i);
  assign newline = wrap_cursor('0, {1'b0, row_q} + ROWS_W'(1), grid_i);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    adv_d   = adv_q;
    glyph_d = glyph_q;
    fg_d    = fg_q;
    bg_d    = bg_q;
    if (cmd_i.load) begin
      fg_d = fg_color_i;
      bg_d = bg_color_i;
      unique case (char_code_i)
        CHAR_NEWLINE: begin
          col_d = newline.col;
          row_d = newline.row;
        end
        CHAR_BACKSPACE: begin
          glyph_d = CHAR_SPACE;
          adv_d   = 1'b0;
          cnt_d   = CNT_W'(1);
          if (col_q == '0) begin
            col_d = COL_W'(grid_i.cols - COLS_W'(1));
            if (row_q == '0) begin
              row_d = ROW_W'(grid_i.rows - ROWS_W'(1));
            end else begin
              row_d = row_q - ROW_W'(1);
            end
          end else begin
            col_d = col_q - COL_W'(1);
          end
        end
        CHAR_TAB: begin
          glyph_d = CHAR_SPACE;
          adv_d   = 1'b1;
          cnt_d   = tab_cnt;
        end
        default: begin
          glyph_d = char_code_i;
          adv_d   = 1'b1;
          cnt_d   = CNT_W'(1);
        end
      endcase
    end else if (cmd_i.step) begin
      col_d = stepped.col;
      row_d = stepped.row;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
      adv_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
      adv_q <= adv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q <= glyph_d;
    fg_q    <= fg_d;
    bg_q    <= bg_d;
  end

  assign cell_col_o = col_q;
  assign cell_row_o = row_q;
  assign glyph_o    = glyph_q;
  assign draw_fg_o  = fg_q;
  assign draw_bg_o  = bg_q;
  assign last_o     = status_o.last;

endmodule

FILE: design/text_console_cursor_engine.sv
// Text console cursor engine: each character request (byte plus foreground and
// background colour) moves a cursor on a grid set by the column and row
// registers and yields cell-draw requests of column, row, glyph and colours,
// with last marking the final draw of the character. The sequencer takes a
// character and then presents one draw per cycle while the output
// side does not stall, taking no new character until the last draw has gone:
// a printable byte or a backspace yields one draw, a tab one draw for each of its n
// spaces (up to 8), and a newline draws nothing. Grid registers
// sit at byte addresses 0 (columns) and 4 (rows) and should only be written
// while the engine is idle; there is no scrolling, the row wraps to the top.
module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [COLOR_W-1:0] fg_color_i,
  input  logic [COLOR_W-1:0] bg_color_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COL_W-1:0]   cell_col_o,
  output logic [ROW_W-1:0]   cell_row_o,
  output logic [CHAR_W-1:0]  glyph_o,
  output logic [COLOR_W-1:0] draw_fg_o,
  output logic [COLOR_W-1:0] draw_bg_o,
  output logic               last_o
);

`include "text_console_cursor_engine_macros.svh"

  grid_t      grid;
  dp_cmd_t    cmd;
  dp_status_t status;

  tcce_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .grid_o  (grid)
  );

  tcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcce_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_i      (grid),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_code_i (char_code_i),
    .fg_color_i  (fg_color_i),
    .bg_color_i  (bg_color_i),
    .cell_col_o  (cell_col_o),
    .cell_row_o  (cell_row_o),
    .glyph_o     (glyph_o),
    .draw_fg_o   (draw_fg_o),
    .draw_bg_o   (draw_bg_o),
    .last_o      (last_o)
  );

  // While draws are pending no new character may be taken.
  `TCCE_ASSERT_ALWAYS(a_no_accept_while_drawing, out_valid_o |-> in_stall_o, "request taken during draws")
  // A character that draws something is presented in the next cycle.
  `TCCE_ASSERT(a_draw_follows_char, (in_valid_i && !in_stall_o && char_code_i != CHAR_NEWLINE) |=> out_valid_o, "draw missing after character")
  // A draw that is not the last is followed by another.
  `TCCE_ASSERT(a_burst_continues, (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o, "draw burst cut short")
  // The last draw ends the burst.
  `TCCE_ASSERT(a_burst_ends, (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o, "draw after last")

endmodule

FILE: tb/text_console_cursor_engine_test.sv
module text_console_cursor_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1
  } grid_reg_e;

  typedef struct {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic               last;
  } cell_draw_t;

  localparam int IDLE_LIMIT = 2000;

  // Tracks the cursor and the grid registers and holds the cell draws still owed.
  class draw_scoreboard;
    int unsigned cols_reg;
    int unsigned rows_reg;
    int unsigned cur_col;
    int unsigned cur_row;
    cell_draw_t  owed_draws[$];
    int          errors;

    function new();
      cols_reg = RESET_COLS;
      rows_reg = RESET_ROWS;
      cur_col  = 0;
      cur_row  = 0;
      errors   = 0;
    endfunction

    function void write_register(grid_reg_e idx, logic [31:0] value);
      case (idx)
        REG_COLUMNS: cols_reg = value & 32'h3FF;
        REG_ROWS:    rows_reg = value & 32'h1FF;
        default: ;
      endcase
    endfunction

    function int unsigned grid_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
    endfunction

    function int unsigned grid_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
    endfunction

    function void wrap_position();
      if (cur_col >= grid_cols()) begin
        cur_row++;
        cur_col = 0;
      end
      if (cur_row >= grid_rows()) cur_row = 0;
      cur_col &= 32'h1FF;
      cur_row &= 32'hFF;
    endfunction

    function void owe_draw(logic [CHAR_W-1:0] glyph, logic [COLOR_W-1:0] fg,
                           logic [COLOR_W-1:0] bg);
      cell_draw_t d;
      d.col   = COL_W'(cur_col);
      d.row   = ROW_W'(cur_row);
      d.glyph = glyph;
      d.fg    = fg;
      d.bg    = bg;
      d.last  = 1'b0;
      owed_draws.push_back(d);
    endfunction

    function void note_request(logic [CHAR_W-1:0] code, logic [COLOR_W-1:0] fg,
                               logic [COLOR_W-1:0] bg);
      int unsigned first;
      int unsigned spaces;
      first = owed_draws.size();
      case (code)
        CHAR_NEWLINE: begin
          cur_row++;
          cur_col = 0;
          wrap_position();
        end
        CHAR_BACKSPACE: begin
          if (cur_col == 0) begin
            cur_col = grid_cols() - 1;
            if (cur_row == 0) cur_row = grid_rows() - 1;
            else cur_row--;
          end else begin
            cur_col--;
          end
          owe_draw(CHAR_SPACE, fg, bg);
          wrap_position();
        end
        CHAR_TAB: begin
          spaces = TAB_STOP - (cur_col % TAB_STOP);
          if (spaces > MAX_DRAWS) spaces = MAX_DRAWS;
          repeat (spaces) begin
            owe_draw(CHAR_SPACE, fg, bg);
            cur_col++;
            wrap_position();
          end
        end
        default: begin
          owe_draw(code, fg, bg);
          cur_col++;
          wrap_position();
        end
      endcase
      if (owed_draws.size() > first) owed_draws[owed_draws.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_draw(cell_draw_t got);
      cell_draw_t want;
      if (owed_draws.size() == 0) begin
        $error("draw at col %0d row %0d with nothing expected", got.col, got.row);
        errors++;
        return;
      end
      want = owed_draws.pop_front();
      compare_field("cell_col", 32'(want.col), 32'(got.col));
      compare_field("cell_row", 32'(want.row), 32'(got.row));
      compare_field("glyph", 32'(want.glyph), 32'(got.glyph));
      compare_field("draw_fg", want.fg, got.fg);
      compare_field("draw_bg", want.bg, got.bg);
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction

    function int unsigned pending();
      return owed_draws.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [CHAR_W-1:0]  char_code_i = '0;
  logic [COLOR_W-1:0] fg_color_i  = '0;
  logic [COLOR_W-1:0] bg_color_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [COL_W-1:0]   cell_col_o;
  logic [ROW_W-1:0]   cell_row_o;
  logic [CHAR_W-1:0]  glyph_o;
  logic [COLOR_W-1:0] draw_fg_o;
  logic [COLOR_W-1:0] draw_bg_o;
  logic               last_o;

  draw_scoreboard sb;
  bit             in_calm  = 1'b0;
  bit             out_calm = 1'b0;
  int unsigned    idle_cycles = 0;

  text_console_cursor_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .fg_color_i  (fg_color_i),
    .bg_color_i  (bg_color_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_col_o  (cell_col_o),
    .cell_row_o  (cell_row_o),
    .glyph_o     (glyph_o),
    .draw_fg_o   (draw_fg_o),
    .draw_bg_o   (draw_bg_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Requests are noted before draws are checked; the engine never takes a
  // character in the same cycle as one of its draws.
  always @(posedge clk_i) begin
    cell_draw_t got;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(char_code_i, fg_color_i, bg_color_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got.col   = cell_col_o;
        got.row   = cell_row_o;
        got.glyph = glyph_o;
        got.fg    = draw_fg_o;
        got.bg    = draw_bg_o;
        got.last  = last_o;
        sb.check_draw(got);
        moved = 1'b1;
      end
      if (psel && penable && pwrite && pready) moved = 1'b1;
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Draw side: random stalls before each accepted draw, with calm stretches.
  initial begin
    int unsigned hold;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 9);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_char(logic [CHAR_W-1:0] code, logic [COLOR_W-1:0] fg,
                           logic [COLOR_W-1:0] bg);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    fg_color_i  <= fg;
    bg_color_i  <= bg;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [COLOR_W-1:0] random_color();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_random_char();
    int unsigned        pick;
    logic [CHAR_W-1:0]  code;
    pick = $urandom_range(0, 99);
    if (pick < 15) code = CHAR_NEWLINE;
    else if (pick < 30) code = CHAR_BACKSPACE;
    else if (pick < 45) code = CHAR_TAB;
    else code = CHAR_W'($urandom_range(0, 255));
    send_char(code, random_color(), random_color());
  endtask

  // Let the monitor note the last request first, then wait for every owed draw
  // and for the settle time, since a newline owes nothing.
  task automatic drain(int unsigned settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic apb_write(grid_reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(logic [31:0] cols, logic [31:0] rows);
    drain(4);
    apb_write(REG_COLUMNS, cols);
    apb_write(REG_ROWS, rows);
  endtask

  initial begin
    int unsigned plan_cols [11];
    int unsigned plan_rows [11];
    plan_cols = '{13, 300, 5, 512, 640, 1, 9, 2, 1023, 17, 80};
    plan_rows = '{5, 200, 2, 256, 400, 1, 257, 3, 0, 11, 25};
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset grid of 80 by 25: backspace from the top-left corner goes to the
    // bottom-right cell, and the following character wraps back to the top.
    send_char(CHAR_BACKSPACE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_char(8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
    send_char(8'hFF, 32'hAAAA_AAAA, 32'h5555_5555);
    send_char(CHAR_TAB, 32'h5555_5555, 32'hAAAA_AAAA);
    send_char(CHAR_TAB, 32'h1234_5678, 32'h8765_4321);
    send_char(CHAR_NEWLINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_char(8'h41, 32'hAAAA_AAAA, 32'h5555_5555);
    send_char(CHAR_BACKSPACE, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    send_char(CHAR_SPACE, 32'h5555_5555, 32'hAAAA_AAAA);
    send_char(8'h7F, 32'h0000_0001, 32'h8000_0000);
    send_char(8'h80, 32'h8000_0000, 32'h0000_0001);

    // One-cell grid: a newline parks the cursor at the origin, a tab draws
    // a full run of spaces on the same cell.
    set_grid(1, 1);
    send_char(CHAR_NEWLINE, 32'h0, 32'h0);
    send_char(CHAR_TAB, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    send_char(8'h62, 32'h0, 32'hFFFF_FFFF);

    // Out-of-range sizes clamp to the largest grid.
    set_grid(1023, 511);
    send_char(CHAR_BACKSPACE, 32'h1111_1111, 32'h2222_2222);
    send_char(8'hFE, 32'h3333_3333, 32'h4444_4444);
    send_char(CHAR_BACKSPACE, 32'h5555_5555, 32'h6666_6666);
    send_char(CHAR_TAB, 32'h7777_7777, 32'h8888_8888);
    send_char(CHAR_BACKSPACE, 32'h9999_9999, 32'hAAAA_AAAA);

    // Shrinking the grid leaves the cursor outside it until the next step.
    set_grid(7, 3);
    send_char(CHAR_BACKSPACE, 32'hBBBB_BBBB, 32'hCCCC_CCCC);
    send_char(8'h78, 32'hDDDD_DDDD, 32'hEEEE_EEEE);

    // Zero sizes count as one.
    set_grid(0, 0);
    send_char(8'h71, 32'hFFFF_0000, 32'h0000_FFFF);
    send_char(CHAR_BACKSPACE, 32'h0000_FFFF, 32'hFFFF_0000);

    foreach (plan_cols[p]) begin
      set_grid(plan_cols[p], plan_rows[p]);
      repeat (21) send_random_char();
    end

    drain(20);
    if (sb.pending() != 0) begin
      $error("%0d draws never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
